// ===== sv/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, widths and codes for the bitmap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  // Built capacity and bitmap organization
  localparam int CAPACITY    = 1024;
  localparam int GROUP_BITS  = 64;
  localparam int GROUP_COUNT = (CAPACITY + GROUP_BITS - 1) / GROUP_BITS;

  localparam int SLOT_IDX_W  = $clog2(CAPACITY);
  localparam int BIT_W       = $clog2(GROUP_BITS);
  localparam int GROUP_IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int CNT_W       = 11;
  localparam int STRIDE_W    = 13;
  localparam int ADDR_W      = 64;
  localparam int OFFSET_W    = SLOT_IDX_W + STRIDE_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef logic [GROUP_BITS-1:0]  word_t;
  typedef logic [GROUP_IDX_W-1:0] group_idx_t;
  typedef logic [SLOT_IDX_W-1:0]  slot_idx_t;
  typedef logic [BIT_W-1:0]       bit_idx_t;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_IGNORED = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_EN   = 3'd4;

  // Input transaction
  typedef struct packed {
    logic            command;
    slot_idx_t       release_index;
    logic            release_valid;
  } in_t;

  // Result transaction
  typedef struct packed {
    status_t           status;
    slot_idx_t         slot_index;
    logic [ADDR_W-1:0] primary_address;
    logic [ADDR_W-1:0] secondary_address;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic scan;
    logic mul;
    logic add;
    logic release_slot;
    logic report_none;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic found;
    logic last_group;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/bsa_datapath.sv =====
// ----------------------------------------------------------------------------
// bsa_datapath
// Configuration registers, free bitmap, group scan, offset multiply, address
// add and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_datapath
  import bsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_t                   in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  output out_t                       out_data
);

  // Lowest set bit of a group word
  function automatic bit_idx_t lowest_set(input word_t w);
    bit_idx_t pos;
    pos = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = bit_idx_t'(i);
      end
    end
    return pos;
  endfunction

  logic [CNT_W-1:0]    slot_count_r;
  logic [ADDR_W-1:0]   primary_base_r;
  logic [ADDR_W-1:0]   secondary_base_r;
  logic [STRIDE_W-1:0] slot_stride_r;
  logic                secondary_en_r;

  word_t               free_map_r [GROUP_COUNT];
  group_idx_t          grp_r;
  slot_idx_t           rel_idx_r;
  logic                rel_valid_r;
  slot_idx_t           found_idx_r;
  logic [OFFSET_W-1:0] offset_r;
  out_t                out_r;

  logic [CNT_W-1:0]       eff_cnt;
  logic [CNT_W-BIT_W-1:0] eff_hi;
  logic [CNT_W-BIT_W-1:0] grp_ext;
  word_t                  cnt_mask;
  word_t                  scan_word;
  bit_idx_t               scan_pos;
  logic                   rel_in_range;
  group_idx_t             rel_grp;
  bit_idx_t               rel_bit;
  logic [ADDR_W-1:0]      offset_ext;

  // Saturate the slot count to the built capacity
  assign eff_cnt = (slot_count_r > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : slot_count_r;
  assign eff_hi  = eff_cnt[CNT_W-1:BIT_W];
  assign grp_ext = (CNT_W-BIT_W)'(grp_r);

  // Mask off slots at or beyond the count within the current group
  always_comb begin
    if (eff_hi > grp_ext) begin
      cnt_mask = '1;
    end else if (eff_hi == grp_ext) begin
      cnt_mask = (word_t'(1) << eff_cnt[BIT_W-1:0]) - word_t'(1);
    end else begin
      cnt_mask = '0;
    end
  end

  assign scan_word = free_map_r[grp_r] & cnt_mask;
  assign scan_pos  = lowest_set(scan_word);

  assign sts.found      = |scan_word;
  assign sts.last_group = (grp_r == group_idx_t'(GROUP_COUNT - 1));

  assign rel_in_range = ({1'b0, rel_idx_r} < eff_cnt);
  assign rel_grp      = group_idx_t'(rel_idx_r >> BIT_W);
  assign rel_bit      = rel_idx_r[BIT_W-1:0];
  assign offset_ext   = ADDR_W'(offset_r);

  // Configuration registers and free bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r     <= CNT_W'(1024);
      primary_base_r   <= '0;
      secondary_base_r <= '0;
      slot_stride_r    <= STRIDE_W'(32);
      secondary_en_r   <= 1'b0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
        free_map_r[g] <= '1;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_COUNT:     slot_count_r     <= cfg_data[CNT_W-1:0];
          CFG_PRIMARY_BASE:   primary_base_r   <= cfg_data;
          CFG_SECONDARY_BASE: secondary_base_r <= cfg_data;
          CFG_SLOT_STRIDE:    slot_stride_r    <= cfg_data[STRIDE_W-1:0];
          CFG_SECONDARY_EN:   secondary_en_r   <= cfg_data[0];
          default: ;
        endcase
      end
      // Mark the found slot used
      if (cmd.scan && sts.found) begin
        free_map_r[grp_r][scan_pos] <= 1'b0;
      end
      // Mark a released slot free
      if (cmd.release_slot && rel_valid_r && rel_in_range) begin
        free_map_r[rel_grp][rel_bit] <= 1'b1;
      end
    end
  end

  // Operand capture, scan pointer, offset and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rel_idx_r   <= in_data.release_index;
      rel_valid_r <= in_data.release_valid;
      grp_r       <= '0;
    end else if (cmd.scan) begin
      grp_r <= grp_r + group_idx_t'(1);
    end

    if (cmd.scan && sts.found) begin
      found_idx_r <= slot_idx_t'({grp_r, scan_pos});
    end

    if (cmd.mul) begin
      offset_r <= OFFSET_W'(found_idx_r) * OFFSET_W'(slot_stride_r);
    end

    if (cmd.add) begin
      out_r.status            <= ST_OK;
      out_r.slot_index        <= found_idx_r;
      out_r.primary_address   <= primary_base_r + offset_ext;
      out_r.secondary_address <= secondary_en_r ? (secondary_base_r + offset_ext) : '0;
    end else if (cmd.report_none) begin
      out_r.status            <= ST_NONE;
      out_r.slot_index        <= '0;
      out_r.primary_address   <= '0;
      out_r.secondary_address <= '0;
    end else if (cmd.release_slot) begin
      if (!rel_valid_r) begin
        out_r.status <= ST_IGNORED;
      end else if (!rel_in_range) begin
        out_r.status <= ST_RANGE;
      end else begin
        out_r.status <= ST_OK;
      end
      out_r.slot_index        <= '0;
      out_r.primary_address   <= '0;
      out_r.secondary_address <= '0;
    end
  end

  assign out_data = out_r;

  // A reported no-free result never carries an index or address
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.report_none) |-> (out_r.slot_index == '0 && out_r.primary_address == '0))
    else $error("no-free result carries nonzero fields");

  // A found slot is below the effective count
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.found) |-> ({1'b0, grp_r, scan_pos} < {1'b0, eff_cnt}))
    else $error("scan picked a slot beyond the count");

  // A found slot is cleared in the bitmap on the next cycle
  a_found_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.found) |=> !free_map_r[$past(grp_r)][$past(scan_pos)])
    else $error("found slot not cleared");

endmodule

`default_nettype wire

// ===== sv/bsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsa_ctrl
// Command sequencer: accepts a command, steps the group scan, the address
// computation or the release, and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl
  import bsa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    in_command,
  input  wire dp_sts_t sts,
  output logic         busy,
  output dp_cmd_t      cmd,
  output logic         out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_FREE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_command == CMD_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_nxt = S_MUL;
        end else if (sts.last_group) begin
          cmd.report_none = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FREE: begin
        cmd.release_slot = 1'b1;
        out_valid_nxt    = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // The strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  // Every finished command produces a result
  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("command finished without a result");

  // A strobe only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result strobe without a command in flight");

endmodule

`default_nettype wire

// ===== sv/bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-fit slot allocator over a free bitmap with address generation.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown on out_data for one cycle with out_valid high,
// and the receiver cannot stall it. A free goes from acceptance through the
// release state to the strobe. An allocate runs the sequential group scan,
// one bitmap group per cycle, up to group g (0 to 15), the group of 64 slots
// holding the lowest free slot, then the multiply state and the address add
// state. When no slot is free the scan covers all 16 groups and the result
// follows the last group. busy drops on the cycle the result is shown, so a
// new command can be taken then.
// Configuration writes are taken at any edge with cfg_we high; write them
// only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator
  import bsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_data.command),
    .sts        (dp_sts),
    .busy       (busy),
    .cmd        (dp_cmd),
    .out_valid  (out_valid)
  );

  bsa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/bitmap_slot_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_checker
// Watches the command, result and register ports of the slot allocator. It
// keeps its own free bitmap and register copies, predicts one result per
// accepted command and compares every strobed result, field by field, with
// the oldest prediction. It hands the failure count and the number of
// results still due to the testbench top.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_checker
  import bsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  // Shadow state: 1 = slot free
  logic [CAPACITY-1:0] free_slots;
  logic [CNT_W-1:0]    slot_count;
  logic [ADDR_W-1:0]   primary_base;
  logic [ADDR_W-1:0]   secondary_base;
  logic [STRIDE_W-1:0] slot_stride;
  logic                secondary_en;

  out_t pending_results[$];

  // Work out the result of one command and update the shadow bitmap
  function automatic out_t predict_slot_result(in_t cmd);
    out_t              res;
    int unsigned       limit;
    int unsigned       idx;
    logic              found;
    logic [ADDR_W-1:0] offset;
    res = '0;
    res.status = ST_OK;
    found = 1'b0;
    // Counts past the built capacity saturate
    limit = (slot_count > CAPACITY) ? CAPACITY : slot_count;
    if (cmd.command == CMD_ALLOC) begin
      for (idx = 0; idx < limit; idx++) begin
        if (!found && free_slots[idx]) begin
          found = 1'b1;
          free_slots[idx] = 1'b0;
          offset = ADDR_W'(idx) * ADDR_W'(slot_stride);
          res.slot_index = slot_idx_t'(idx);
          res.primary_address = primary_base + offset;
          res.secondary_address = secondary_en ? secondary_base + offset : '0;
        end
      end
      if (!found) res.status = ST_NONE;
    end else if (!cmd.release_valid) begin
      res.status = ST_IGNORED;
    end else if (cmd.release_index >= limit) begin
      res.status = ST_RANGE;
    end else begin
      free_slots[cmd.release_index] = 1'b1;
    end
    return res;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Check results, track register writes, predict accepted commands
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      free_slots     = '1;
      slot_count     = CNT_W'(1024);
      primary_base   = '0;
      secondary_base = '0;
      slot_stride    = STRIDE_W'(32);
      secondary_en   = 1'b0;
      pending_results.delete();
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result status %0d slot %0d pri %h sec %h",
                                 out_data.status, out_data.slot_index,
                                 out_data.primary_address, out_data.secondary_address));
        end else begin
          exp_res = pending_results.pop_front();
          if (out_data.status !== exp_res.status ||
              out_data.slot_index !== exp_res.slot_index ||
              out_data.primary_address !== exp_res.primary_address ||
              out_data.secondary_address !== exp_res.secondary_address) begin
            log_mismatch($sformatf(
              "exp status %0d slot %0d pri %h sec %h, got status %0d slot %0d pri %h sec %h",
              exp_res.status, exp_res.slot_index, exp_res.primary_address,
              exp_res.secondary_address, out_data.status, out_data.slot_index,
              out_data.primary_address, out_data.secondary_address));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_COUNT:     slot_count     = cfg_data[CNT_W-1:0];
          CFG_PRIMARY_BASE:   primary_base   = cfg_data;
          CFG_SECONDARY_BASE: secondary_base = cfg_data;
          CFG_SLOT_STRIDE:    slot_stride    = cfg_data[STRIDE_W-1:0];
          CFG_SECONDARY_EN:   secondary_en   = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) pending_results.push_back(predict_slot_result(in_data));
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== dv/bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_tb
// Stimulus and verdict for the bitmap slot allocator. A short directed part
// covers the status codes, saturation, a lowered count and address wrap; a
// fill sequence drives the bitmap to full; random phases then mix allocate
// and free commands under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  in_t                   in_data   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  out_valid;
  out_t                  out_data;
  int unsigned           mismatches;
  int unsigned           outstanding;

  // Effective slot count, used to aim free commands at live slots
  int unsigned           live_count = CAPACITY;

  always #6 clk = ~clk;

  bitmap_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bitmap_slot_allocator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic in_t make_cmd(logic command, int unsigned index, logic valid);
    in_t cmd;
    cmd.command       = command;
    cmd.release_index = slot_idx_t'(index);
    cmd.release_valid = valid;
    return cmd;
  endfunction

  // Random command; frees mostly aim just around the live slot range
  function automatic in_t random_cmd(int unsigned alloc_pct);
    int unsigned hi;
    in_t         cmd;
    hi = (live_count + 1 > CAPACITY - 1) ? CAPACITY - 1 : live_count + 1;
    cmd.command       = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
    cmd.release_valid = ($urandom_range(0, 9) != 0);
    cmd.release_index = ($urandom_range(0, 4) == 0) ? slot_idx_t'($urandom)
                                                    : slot_idx_t'($urandom_range(0, hi));
    return cmd;
  endfunction

  // Pick a slot count with junk in the unused upper bits
  function automatic logic [CFG_DATA_W-1:0] random_count();
    logic [CFG_DATA_W-1:0] word;
    logic [CNT_W-1:0]      count;
    case ($urandom_range(0, 5))
      0:       count = '0;
      1:       count = CNT_W'(1);
      2:       count = CNT_W'($urandom_range(2, 80));
      3:       count = CNT_W'(CAPACITY);
      4:       count = '1;
      default: count = CNT_W'($urandom);
    endcase
    word = {$urandom, $urandom};
    word[CNT_W-1:0] = count;
    return word;
  endfunction

  // Present one transaction and hold it until accepted; returns at a falling edge
  task automatic send_item(in_t item);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Wait until every predicted result has come and the block is idle
  task automatic drain();
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all registers; only called after drain with start low
  task automatic write_config(logic [CFG_DATA_W-1:0] count_word,
                              logic [CFG_DATA_W-1:0] pri_base,
                              logic [CFG_DATA_W-1:0] sec_base,
                              logic [CFG_DATA_W-1:0] stride_word,
                              logic [CFG_DATA_W-1:0] sec_en_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOT_COUNT;
    cfg_data  <= count_word;
    @(negedge clk);
    cfg_index <= CFG_PRIMARY_BASE;
    cfg_data  <= pri_base;
    @(negedge clk);
    cfg_index <= CFG_SECONDARY_BASE;
    cfg_data  <= sec_base;
    @(negedge clk);
    cfg_index <= CFG_SLOT_STRIDE;
    cfg_data  <= stride_word;
    @(negedge clk);
    cfg_index <= CFG_SECONDARY_EN;
    cfg_data  <= sec_en_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    live_count = (count_word[CNT_W-1:0] > CAPACITY) ? CAPACITY : count_word[CNT_W-1:0];
  endtask

  // Random transactions with sender gaps and an occasional full drain
  task automatic run_items(int unsigned n, int unsigned alloc_pct, int unsigned idle_pct);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) == 0) begin
        start <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(negedge clk);
      end
      send_item(random_cmd(alloc_pct));
    end
    start <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned idle_pct;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values: allocate, free, already-free, ignored handle
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    send_item(make_cmd(CMD_ALLOC, 1023, 1'b1));
    send_item(make_cmd(CMD_FREE, 1, 1'b1));
    send_item(make_cmd(CMD_FREE, 1023, 1'b1));
    send_item(make_cmd(CMD_FREE, 0, 1'b0));
    start <= 1'b0;
    drain();

    // Three slots, full stride, addresses wrap past the top
    write_config({53'h1f_ffff_ffff_ffff, 11'd3}, 64'hffff_ffff_ffff_ffc0,
                 64'h8000_0000_0000_0000, 64'h1fff, 64'h1);
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    send_item(make_cmd(CMD_FREE, 3, 1'b1));
    send_item(make_cmd(CMD_FREE, 1023, 1'b1));
    send_item(make_cmd(CMD_FREE, 2, 1'b0));
    send_item(make_cmd(CMD_FREE, 2, 1'b1));
    send_item(make_cmd(CMD_ALLOC, 0, 1'b1));
    start <= 1'b0;
    drain();

    // Count lowered below slots in use, zero stride
    write_config(64'd1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'd0, 64'd0);
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    send_item(make_cmd(CMD_FREE, 1, 1'b1));
    send_item(make_cmd(CMD_FREE, 0, 1'b1));
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    start <= 1'b0;
    drain();

    // Count past capacity saturates
    write_config(64'h7ff, {$urandom, $urandom}, 64'hffff_ffff_ffff_ffff, 64'd4096, 64'h1);
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    send_item(make_cmd(CMD_FREE, 1023, 1'b1));
    send_item(make_cmd(CMD_FREE, 1, 1'b1));
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    start <= 1'b0;
    drain();

    // Zero slots: nothing to hand out, every index out of range
    write_config(64'd0, 64'd0, 64'd0, 64'd32, 64'd0);
    send_item(make_cmd(CMD_ALLOC, 0, 1'b0));
    send_item(make_cmd(CMD_FREE, 0, 1'b1));
    start <= 1'b0;
    drain();

    // Fill the low 640 slots, then run past them
    write_config(64'd640, {$urandom, $urandom}, {$urandom, $urandom},
                 64'($urandom_range(0, 8191)), 64'h1);
    run_items(645, 100, 0);
    drain();

    // Random phases over several settings and idle rates
    for (phase = 0; phase < 9; phase++) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 78;
        default: idle_pct = 10;
      endcase
      write_config(random_count(),
                   ($urandom_range(0, 3) == 0) ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom},
                   ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom},
                   ($urandom_range(0, 2) == 0) ? {$urandom, 19'd0, 13'h1fff}
                                               : 64'($urandom_range(0, 4096)),
                   {$urandom, $urandom});
      run_items(37, $urandom_range(30, 70), idle_pct);
      drain();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bsa_pkg.sv
sv/bsa_datapath.sv
sv/bsa_ctrl.sv
sv/bitmap_slot_allocator.sv
dv/bitmap_slot_allocator_checker.sv
dv/bitmap_slot_allocator_tb.sv
